// ===== rtl/core/indexed_priority_queue_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed priority queue unit: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define INDEXED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ipq check failed");

// next-cycle implication, disabled while in reset
`define IPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ipq check failed");

`endif

// ===== rtl/core/ipq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed priority queue package
// Field widths, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ipq_pkg;

	localparam int VALUE_W  = 32;
	localparam int HANDLE_W = 12;
	localparam int COUNT_W  = 11;
	localparam int FUNC_W   = 3;

	// operation codes on the func port
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT      = 3'd0,
		FN_GET_MIN     = 3'd1,
		FN_EXTRACT_MIN = 3'd2,
		FN_DELETE      = 3'd3,
		FN_CHANGE      = 3'd4,
		FN_CLEAR       = 3'd5,
		FN_SIZE        = 3'd6
	} ipq_func_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_CHECK,
		ST_SCAN,
		ST_RISE,
		ST_SINK
	} ipq_state_t;

endpackage

// ===== rtl/core/indexed_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Indexed priority queue unit
// A max-ordered binary heap of signed values with handles; the minimum is
// found by a scan over the leaves.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result word
// appears on status, min_value and count for a single cycle with done high, and
// must be captured then. Size, clear, unused codes and commands rejected at
// decode finish at decode. Insert climbs from the new last position one
// level per step. Delete and change pass the handle lookup and check (a stale
// handle is rejected there, and deleting the last cell ends there), then climb
// and sink one level per step. Get and extract scan the leaves one position a
// cycle, (count+1)/2 positions, which dominates for a large heap; extract then
// climbs like insert. The scan length is set by its single read per cycle on
// read chain a of the heap level memories; each sift step reads and writes
// together because every heap level sits in its own cell with its own memory.
module indexed_priority_queue_unit import ipq_pkg::*; #(
	parameter int CAPACITY     = 1024,
	parameter int HANDLE_LIMIT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [FUNC_W-1:0]         func,
	input  logic [HANDLE_W-1:0]       handle,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      busy,
	output logic                      done,
	output logic                      status,
	output logic signed [VALUE_W-1:0] min_value,
	output logic [COUNT_W-1:0]        count
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int HW = $clog2(HANDLE_LIMIT);

	logic                      heap_we;
	logic [PW:0]               heap_wpos, heap_rpos_a, heap_rpos_b;
	logic signed [VALUE_W-1:0] heap_wval;
	logic [HW-1:0]             heap_whdl;

	// read chain through the level cells
	logic signed [VALUE_W-1:0] a_val_c [PW+1];
	logic [HW-1:0]             a_hdl_c [PW+1];
	logic signed [VALUE_W-1:0] b_val_c [PW+1];
	logic [HW-1:0]             b_hdl_c [PW+1];

	assign a_val_c[0] = '0;
	assign a_hdl_c[0] = '0;
	assign b_val_c[0] = '0;
	assign b_hdl_c[0] = '0;

	ipq_ctrl #(
		.CAPACITY     (CAPACITY),
		.HANDLE_LIMIT (HANDLE_LIMIT),
		.PW           (PW),
		.HW           (HW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.handle      (handle),
		.value       (value),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.min_value   (min_value),
		.count       (count),
		.heap_we     (heap_we),
		.heap_wpos   (heap_wpos),
		.heap_wval   (heap_wval),
		.heap_whdl   (heap_whdl),
		.heap_rpos_a (heap_rpos_a),
		.heap_rpos_b (heap_rpos_b),
		.rd_a_val    (a_val_c[PW]),
		.rd_a_hdl    (a_hdl_c[PW]),
		.rd_b_val    (b_val_c[PW]),
		.rd_b_hdl    (b_hdl_c[PW])
	);

	// one cell per heap level
	for (genvar k = 0; k < PW; k++) begin : g_level
		ipq_level #(
			.LEVEL (k),
			.PW    (PW),
			.HW    (HW)
		) u_level (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (heap_we),
			.wr_pos    (heap_wpos),
			.wr_val    (heap_wval),
			.wr_hdl    (heap_whdl),
			.rd_pos_a  (heap_rpos_a),
			.rd_pos_b  (heap_rpos_b),
			.in_a_val  (a_val_c[k]),
			.in_a_hdl  (a_hdl_c[k]),
			.in_b_val  (b_val_c[k]),
			.in_b_hdl  (b_hdl_c[k]),
			.out_a_val (a_val_c[k+1]),
			.out_a_hdl (a_hdl_c[k+1]),
			.out_b_val (b_val_c[k+1]),
			.out_b_hdl (b_hdl_c[k+1])
		);
	end

endmodule

// ===== rtl/core/ipq_level.sv =====
// ----------------------------------------------------------------------------
// Heap level cell
// Holds one level of the heap (positions 2^LEVEL .. 2^(LEVEL+1)-1) and
// merges its registered read words into the read chain from its neighbor.
// ----------------------------------------------------------------------------
module ipq_level import ipq_pkg::*; #(
	parameter int LEVEL = 0,
	parameter int PW    = 11,
	parameter int HW    = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [PW:0]               wr_pos,
	input  logic signed [VALUE_W-1:0] wr_val,
	input  logic [HW-1:0]             wr_hdl,
	input  logic [PW:0]               rd_pos_a,
	input  logic [PW:0]               rd_pos_b,
	input  logic signed [VALUE_W-1:0] in_a_val,
	input  logic [HW-1:0]             in_a_hdl,
	input  logic signed [VALUE_W-1:0] in_b_val,
	input  logic [HW-1:0]             in_b_hdl,
	output logic signed [VALUE_W-1:0] out_a_val,
	output logic [HW-1:0]             out_a_hdl,
	output logic signed [VALUE_W-1:0] out_b_val,
	output logic [HW-1:0]             out_b_hdl
);

	localparam int OW    = (LEVEL == 0) ? 1 : LEVEL;
	localparam int DEPTH = 1 << LEVEL;

	logic signed [VALUE_W-1:0] val_mem [DEPTH];
	logic [HW-1:0]             hdl_mem [DEPTH];

	logic              wr_hit, a_hit, b_hit;
	logic [OW-1:0]     wr_ofs, a_ofs, b_ofs;
	logic              a_hit_q, b_hit_q;
	logic signed [VALUE_W-1:0] a_val_q, b_val_q;
	logic [HW-1:0]     a_hdl_q, b_hdl_q;

	// position decode: the level is the position's leading one
	assign wr_hit = (wr_pos >> LEVEL) == (PW+1)'(1);
	assign a_hit  = (rd_pos_a >> LEVEL) == (PW+1)'(1);
	assign b_hit  = (rd_pos_b >> LEVEL) == (PW+1)'(1);
	assign wr_ofs = (LEVEL == 0) ? '0 : OW'(wr_pos);
	assign a_ofs  = (LEVEL == 0) ? '0 : OW'(rd_pos_a);
	assign b_ofs  = (LEVEL == 0) ? '0 : OW'(rd_pos_b);

	// level memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en && wr_hit) begin
			val_mem[wr_ofs] <= wr_val;
			hdl_mem[wr_ofs] <= wr_hdl;
		end
		a_val_q <= val_mem[a_ofs];
		a_hdl_q <= hdl_mem[a_ofs];
		b_val_q <= val_mem[b_ofs];
		b_hdl_q <= hdl_mem[b_ofs];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_hit_q <= 1'b0;
			b_hit_q <= 1'b0;
		end else begin
			a_hit_q <= a_hit;
			b_hit_q <= b_hit;
		end
	end

	// merge into the read chain; only the hit level contributes
	assign out_a_val = in_a_val | (a_hit_q ? a_val_q : '0);
	assign out_a_hdl = in_a_hdl | (a_hit_q ? a_hdl_q : '0);
	assign out_b_val = in_b_val | (b_hit_q ? b_val_q : '0);
	assign out_b_hdl = in_b_hdl | (b_hit_q ? b_hdl_q : '0);

endmodule

// ===== rtl/core/ipq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed priority queue sequencer
// Decodes operations, walks sifts and the leaf scan over the level cells,
// and keeps the handle-to-position memory.
// ----------------------------------------------------------------------------
module ipq_ctrl import ipq_pkg::*; #(
	parameter int CAPACITY     = 1024,
	parameter int HANDLE_LIMIT = 4096,
	parameter int PW           = 11,
	parameter int HW           = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [FUNC_W-1:0]         func,
	input  logic [HANDLE_W-1:0]       handle,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      busy,
	output logic                      done,
	output logic                      status,
	output logic signed [VALUE_W-1:0] min_value,
	output logic [COUNT_W-1:0]        count,
	output logic                      heap_we,
	output logic [PW:0]               heap_wpos,
	output logic signed [VALUE_W-1:0] heap_wval,
	output logic [HW-1:0]             heap_whdl,
	output logic [PW:0]               heap_rpos_a,
	output logic [PW:0]               heap_rpos_b,
	input  logic signed [VALUE_W-1:0] rd_a_val,
	input  logic [HW-1:0]             rd_a_hdl,
	input  logic signed [VALUE_W-1:0] rd_b_val,
	input  logic [HW-1:0]             rd_b_hdl
);

	localparam int CW = (HW > HANDLE_W) ? HW : HANDLE_W;

	ipq_state_t state_q, state_d;
	logic [PW-1:0] count_q, count_d, pos_q, pos_d, idx_q, idx_d, best_pos_q, best_pos_d;
	logic [HW-1:0] issued_q, issued_d, mv_hdl_q, mv_hdl_d, handle_q, handle_d;
	logic signed [VALUE_W-1:0] mv_val_q, mv_val_d, value_q, value_d;
	logic signed [VALUE_W-1:0] best_val_q, best_val_d, res_min_q, res_min_d;
	logic [FUNC_W-1:0] func_q, func_d;
	logic do_sink_q, do_sink_d, first_q, first_d;

	logic fin, fin_err;
	logic signed [VALUE_W-1:0] fin_min;
	logic accept;

	// handle-to-position memory
	logic [PW-1:0] hp_mem [HANDLE_LIMIT];
	logic [PW-1:0] hp_rd_q;
	logic          hp_we;
	logic [HW-1:0] hp_waddr;

	// output words
	logic done_q, status_q;
	logic signed [VALUE_W-1:0] min_q;
	logic [COUNT_W-1:0] count_o_q;

	// shared decisions
	logic [PW:0] pos_w, count_w, left_pos, right_pos;
	logic l_ok, r_ok, sel_l, sel_r, rise_up, scan_take, chk_ok, full, bad_handle;
	logic signed [VALUE_W-1:0] big_val, scan_val;
	logic [PW-1:0] scan_pos;

	assign accept    = start && (state_q == ST_IDLE);
	assign pos_w     = {1'b0, pos_q};
	assign count_w   = {1'b0, count_q};
	assign left_pos  = {pos_q, 1'b0};
	assign right_pos = {pos_q, 1'b1};
	assign l_ok      = left_pos <= count_w;
	assign r_ok      = right_pos <= count_w;
	assign sel_l     = l_ok && (rd_a_val > mv_val_q);
	assign big_val   = sel_l ? rd_a_val : mv_val_q;
	assign sel_r     = r_ok && (rd_b_val > big_val);
	assign rise_up   = (pos_q != PW'(1)) && (mv_val_q > rd_a_val);
	assign scan_take = first_q || (rd_a_val < best_val_q);
	assign scan_val  = scan_take ? rd_a_val : best_val_q;
	assign scan_pos  = scan_take ? idx_q : best_pos_q;
	assign chk_ok    = (hp_rd_q != '0) && (hp_rd_q <= count_q) && (rd_a_hdl == handle_q);
	assign full      = (count_q == PW'(CAPACITY)) || (issued_q == HW'(HANDLE_LIMIT - 1));
	assign bad_handle = (handle == '0) || (CW'(handle) > CW'(issued_q));

	// next state and working registers
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		issued_d   = issued_q;
		pos_d      = pos_q;
		idx_d      = idx_q;
		best_pos_d = best_pos_q;
		best_val_d = best_val_q;
		res_min_d  = res_min_q;
		mv_val_d   = mv_val_q;
		mv_hdl_d   = mv_hdl_q;
		handle_d   = handle_q;
		value_d    = value_q;
		func_d     = func_q;
		do_sink_d  = do_sink_q;
		first_d    = first_q;
		fin        = 1'b0;
		fin_err    = 1'b0;
		fin_min    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					func_d   = func;
					handle_d = HW'(handle);
					value_d  = value;
					case (func)
						FN_INSERT: begin
							if (full) begin
								fin     = 1'b1;
								fin_err = 1'b1;
							end else begin
								count_d   = count_q + PW'(1);
								issued_d  = issued_q + HW'(1);
								mv_val_d  = value;
								mv_hdl_d  = issued_q + HW'(1);
								pos_d     = count_q + PW'(1);
								do_sink_d = 1'b0;
								state_d   = ST_RISE;
							end
						end
						FN_GET_MIN, FN_EXTRACT_MIN: begin
							if (count_q == '0) begin
								fin     = 1'b1;
								fin_err = 1'b1;
							end else begin
								idx_d   = (count_q >> 1) + PW'(1);
								first_d = 1'b1;
								state_d = ST_SCAN;
							end
						end
						FN_DELETE, FN_CHANGE: begin
							if (bad_handle) begin
								fin     = 1'b1;
								fin_err = 1'b1;
							end else begin
								state_d = ST_LOOKUP;
							end
						end
						FN_CLEAR: begin
							count_d = '0;
							fin     = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			ST_LOOKUP: state_d = ST_CHECK;
			ST_CHECK: begin
				if (!chk_ok) begin
					fin     = 1'b1;
					fin_err = 1'b1;
				end else if (func_q == FN_DELETE) begin
					count_d = count_q - PW'(1);
					if (hp_rd_q == count_q) begin
						fin = 1'b1;
					end else begin
						mv_val_d  = rd_b_val;
						mv_hdl_d  = rd_b_hdl;
						pos_d     = hp_rd_q;
						do_sink_d = 1'b1;
						state_d   = ST_RISE;
					end
				end else begin
					mv_val_d  = value_q;
					mv_hdl_d  = handle_q;
					pos_d     = hp_rd_q;
					do_sink_d = 1'b1;
					state_d   = ST_RISE;
				end
			end
			ST_SCAN: begin
				best_val_d = scan_val;
				best_pos_d = scan_pos;
				first_d    = 1'b0;
				if (idx_q == count_q) begin
					res_min_d = scan_val;
					if (func_q == FN_GET_MIN) begin
						fin     = 1'b1;
						fin_min = scan_val;
					end else begin
						count_d = count_q - PW'(1);
						if (scan_pos == count_q) begin
							fin     = 1'b1;
							fin_min = scan_val;
						end else begin
							mv_val_d  = rd_a_val;
							mv_hdl_d  = rd_a_hdl;
							pos_d     = scan_pos;
							do_sink_d = 1'b0;
							state_d   = ST_RISE;
						end
					end
				end else begin
					idx_d = idx_q + PW'(1);
				end
			end
			ST_RISE: begin
				if (rise_up) begin
					pos_d = pos_q >> 1;
				end else if (do_sink_q) begin
					state_d = ST_SINK;
				end else begin
					fin     = 1'b1;
					fin_min = (func_q == FN_EXTRACT_MIN) ? res_min_q : '0;
				end
			end
			ST_SINK: begin
				if (sel_r) begin
					pos_d = PW'(right_pos);
				end else if (sel_l) begin
					pos_d = PW'(left_pos);
				end else begin
					fin = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) begin
			state_d = ST_IDLE;
		end
	end

	// memory control: writes for the current step, reads for the next one
	always_comb begin
		heap_we     = 1'b0;
		heap_wpos   = pos_w;
		heap_wval   = mv_val_q;
		heap_whdl   = mv_hdl_q;
		hp_we       = 1'b0;
		hp_waddr    = mv_hdl_q;
		heap_rpos_a = '0;
		heap_rpos_b = '0;
		unique case (state_q)
			ST_RISE: begin
				if (rise_up) begin
					heap_we   = 1'b1;
					heap_wval = rd_a_val;
					heap_whdl = rd_a_hdl;
					hp_we     = 1'b1;
					hp_waddr  = rd_a_hdl;
				end else if (!do_sink_q) begin
					heap_we = 1'b1;
					hp_we   = 1'b1;
				end
			end
			ST_SINK: begin
				heap_we = 1'b1;
				hp_we   = 1'b1;
				if (sel_r) begin
					heap_wval = rd_b_val;
					heap_whdl = rd_b_hdl;
					hp_waddr  = rd_b_hdl;
				end else if (sel_l) begin
					heap_wval = rd_a_val;
					heap_whdl = rd_a_hdl;
					hp_waddr  = rd_a_hdl;
				end
			end
			default: heap_we = 1'b0;
		endcase
		unique case (state_d)
			ST_RISE:  heap_rpos_a = {1'b0, pos_d} >> 1;
			ST_SINK: begin
				heap_rpos_a = {pos_d, 1'b0};
				heap_rpos_b = {pos_d, 1'b1};
			end
			ST_SCAN:  heap_rpos_a = {1'b0, idx_d};
			ST_CHECK: begin
				heap_rpos_a = {1'b0, hp_rd_q};
				heap_rpos_b = count_w;
			end
			default: heap_rpos_a = '0;
		endcase
	end

	// handle-to-position memory
	always_ff @(posedge clk) begin
		if (hp_we) begin
			hp_mem[hp_waddr] <= pos_q;
		end
		if (accept) begin
			hp_rd_q <= hp_mem[HW'(handle)];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			issued_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			issued_q <= issued_d;
			done_q   <= fin;
		end
	end

	// working and result words
	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		idx_q      <= idx_d;
		best_pos_q <= best_pos_d;
		best_val_q <= best_val_d;
		res_min_q  <= res_min_d;
		mv_val_q   <= mv_val_d;
		mv_hdl_q   <= mv_hdl_d;
		handle_q   <= handle_d;
		value_q    <= value_d;
		func_q     <= func_d;
		do_sink_q  <= do_sink_d;
		first_q    <= first_d;
		if (fin) begin
			status_q  <= fin_err;
			min_q     <= fin_err ? '0 : fin_min;
			count_o_q <= COUNT_W'(count_d);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign min_value = min_q;
	assign count     = count_o_q;

endmodule

// ===== rtl/core/ipq_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed priority queue checker
// Port-level properties of the command and result sequencing.
// ----------------------------------------------------------------------------
`include "indexed_priority_queue_unit_defines.svh"

module ipq_checker import ipq_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic                      status,
	input logic signed [VALUE_W-1:0] min_value,
	input logic [COUNT_W-1:0]        count
);

	// an accepted command is either finished or still running
	`IPQ_ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, busy || done)

	// a result word leaves the unit free for the next command
	`IPQ_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)

	// no result without a command behind it
	`IPQ_ASSERT_NEXT(a_no_spurious, clk, arst_n, !busy && !start, !done)

	// errors carry a zero minimum, and the count stays within capacity
	`IPQ_ASSERT_NOW(a_err_min, clk, arst_n, done && status, min_value == '0)
	`IPQ_ASSERT_NOW(a_count_cap, clk, arst_n, done, count <= COUNT_W'(CAPACITY))

endmodule

bind indexed_priority_queue_unit ipq_checker #(.CAPACITY(CAPACITY)) u_ipq_checker (.*);

// ===== tb/sv/indexed_priority_queue_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed priority queue checker
// Watches the command and result channels of the queue. It keeps its own
// max-ordered heap with handle map, predicts the result word of every
// accepted command and compares each done word with the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_priority_queue_unit_checker import ipq_pkg::*; #(
	parameter int CAPACITY     = 1024,
	parameter int HANDLE_LIMIT = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [FUNC_W-1:0]         func,
	input  logic [HANDLE_W-1:0]       handle,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      done,
	input  logic                      status,
	input  logic signed [VALUE_W-1:0] min_value,
	input  logic [COUNT_W-1:0]        count,
	output int                        fail_count,
	output int                        pending,
	output int                        words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                      status;
		logic signed [VALUE_W-1:0] min_value;
		logic [COUNT_W-1:0]        count;
	} result_word_t;

	// shadow heap, positions 1..entry_cnt
	logic signed [VALUE_W-1:0] cell_val [1:CAPACITY];
	logic [HANDLE_W-1:0]       cell_hdl [1:CAPACITY];
	int                        hdl_pos  [0:HANDLE_LIMIT-1];
	int                        entry_cnt;
	int                        last_hdl;
	result_word_t              expected_words[$];

	assign pending = expected_words.size();

	function automatic void swap_cells(int a, int b);
		logic signed [VALUE_W-1:0] tv;
		logic [HANDLE_W-1:0]       th;
		tv = cell_val[a]; th = cell_hdl[a];
		cell_val[a] = cell_val[b]; cell_hdl[a] = cell_hdl[b];
		cell_val[b] = tv; cell_hdl[b] = th;
		hdl_pos[cell_hdl[a]] = a;
		hdl_pos[cell_hdl[b]] = b;
	endfunction

	function automatic int climb(int p);
		while (p > 1 && cell_val[p] > cell_val[p/2]) begin
			swap_cells(p, p/2);
			p = p / 2;
		end
		return p;
	endfunction

	function automatic void descend(int p);
		int l, r, big;
		forever begin
			l = 2*p; r = 2*p + 1; big = p;
			if (l <= entry_cnt && cell_val[l] > cell_val[big]) big = l;
			if (r <= entry_cnt && cell_val[r] > cell_val[big]) big = r;
			if (big == p) return;
			swap_cells(p, big);
			p = big;
		end
	endfunction

	// lowest position wins among equal minima
	function automatic int min_leaf();
		int best;
		best = entry_cnt/2 + 1;
		for (int i = best + 1; i <= entry_cnt; i++)
			if (cell_val[i] < cell_val[best]) best = i;
		return best;
	endfunction

	function automatic void remove_at(int p);
		swap_cells(p, entry_cnt);
		hdl_pos[cell_hdl[entry_cnt]] = 0;
		entry_cnt--;
	endfunction

	function automatic result_word_t queue_op(logic [FUNC_W-1:0] f, int h,
		logic signed [VALUE_W-1:0] v);
		result_word_t w;
		int m, p;
		w = '0;
		case (f)
			FN_INSERT: begin
				if (entry_cnt >= CAPACITY || last_hdl >= HANDLE_LIMIT - 1) begin
					w.status = 1'b1;
				end else begin
					entry_cnt++;
					last_hdl++;
					cell_val[entry_cnt] = v;
					cell_hdl[entry_cnt] = HANDLE_W'(last_hdl);
					hdl_pos[last_hdl] = entry_cnt;
					void'(climb(entry_cnt));
				end
			end
			FN_GET_MIN, FN_EXTRACT_MIN: begin
				if (entry_cnt == 0) begin
					w.status = 1'b1;
				end else begin
					m = min_leaf();
					w.min_value = cell_val[m];
					if (f == FN_EXTRACT_MIN) begin
						remove_at(m);
						if (m <= entry_cnt) void'(climb(m));
					end
				end
			end
			FN_DELETE, FN_CHANGE: begin
				if (h > last_hdl || hdl_pos[h] == 0) begin
					w.status = 1'b1;
				end else begin
					p = hdl_pos[h];
					if (f == FN_DELETE) begin
						remove_at(p);
						if (p <= entry_cnt) descend(climb(p));
					end else begin
						cell_val[p] = v;
						descend(climb(p));
					end
				end
			end
			FN_CLEAR: begin
				for (int i = 1; i <= entry_cnt; i++) hdl_pos[cell_hdl[i]] = 0;
				entry_cnt = 0;
			end
			default: ;
		endcase
		w.count = COUNT_W'(entry_cnt);
		return w;
	endfunction

	initial begin
		for (int i = 0; i < HANDLE_LIMIT; i++) hdl_pos[i] = 0;
		entry_cnt = 0;
		last_hdl = 0;
		fail_count = 0;
		words_checked = 0;
	end

	// compare the done word first, then predict the command taken at this edge
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word status=%0d min=%0d count=%0d",
						$time, status, min_value, count);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						fail_count++;
					end
					if (min_value !== want.min_value) begin
						$display("%0t: min_value expected %0d actual %0d",
							$time, want.min_value, min_value);
						fail_count++;
					end
					if (count !== want.count) begin
						$display("%0t: count expected %0d actual %0d",
							$time, want.count, count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_words.push_back(queue_op(func, handle, value));
		end
	end

endmodule

// ===== tb/sv/indexed_priority_queue_unit_test.sv =====
// ----------------------------------------------------------------------------
// Indexed priority queue testbench
// Drives directed corner commands, a random mix, a fill to capacity and
// stale handle probes, with random gaps; the checker judges results.
// ----------------------------------------------------------------------------
module indexed_priority_queue_unit_test;
	import ipq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 5000;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic [FUNC_W-1:0]         func;
	logic [HANDLE_W-1:0]       handle;
	logic signed [VALUE_W-1:0] value;
	logic                      busy;
	logic                      done;
	logic                      status;
	logic signed [VALUE_W-1:0] min_value;
	logic [COUNT_W-1:0]        count;
	int                        fail_count;
	int                        pending;
	int                        words_checked;
	int                        words_sent;
	int                        inserts_sent;
	int                        idle_cycles;

	indexed_priority_queue_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func), .handle(handle),
		.value(value), .busy(busy), .done(done), .status(status),
		.min_value(min_value), .count(count)
	);

	indexed_priority_queue_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.handle(handle), .value(value), .done(done), .status(status),
		.min_value(min_value), .count(count), .fail_count(fail_count),
		.pending(pending), .words_checked(words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// mostly recent handles, sometimes anything the port allows
	function automatic logic [HANDLE_W-1:0] pick_handle();
		int span;
		if ($urandom_range(0, 9) == 0) return HANDLE_W'($urandom_range(0, 4095));
		span = (inserts_sent < 60) ? inserts_sent : 60;
		return HANDLE_W'(inserts_sent + 2 - $urandom_range(0, span + 2));
	endfunction

	// present one word at a falling edge and hold it until busy is low
	task automatic send_word(logic [FUNC_W-1:0] f, logic [HANDLE_W-1:0] h,
		logic signed [VALUE_W-1:0] v, int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		func = f;
		handle = h;
		value = v;
		while (busy) @(negedge clk);
		@(negedge clk);
		words_sent++;
		if (f == FN_INSERT) inserts_sent++;
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 36)
			send_word(FN_INSERT, HANDLE_W'($urandom), pick_value(), pick_gap());
		else if (r < 46)
			send_word(FN_GET_MIN, HANDLE_W'($urandom), $urandom, pick_gap());
		else if (r < 61)
			send_word(FN_EXTRACT_MIN, HANDLE_W'($urandom), $urandom, pick_gap());
		else if (r < 76)
			send_word(FN_DELETE, pick_handle(), $urandom, pick_gap());
		else if (r < 92)
			send_word(FN_CHANGE, pick_handle(), pick_value(), pick_gap());
		else if (r < 96)
			send_word(FN_SIZE, HANDLE_W'($urandom), $urandom, pick_gap());
		else if (r < 98)
			send_word(FN_CLEAR, HANDLE_W'($urandom), $urandom, pick_gap());
		else
			send_word(FN_UNUSED, HANDLE_W'($urandom), $urandom, pick_gap());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_SIZE;
		handle = '0;
		value = '0;
		words_sent = 0;
		inserts_sent = 0;
		idle_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty queue, bad handles, extremes, ties, stale handles
		send_word(FN_GET_MIN, 0, 0, 0);
		send_word(FN_EXTRACT_MIN, 0, 0, 1);
		send_word(FN_DELETE, 0, 0, 0);
		send_word(FN_CHANGE, 5, 0, 0);
		send_word(FN_SIZE, 0, 0, 0);
		send_word(FN_UNUSED, 12'hfff, 32'hffffffff, 0);
		send_word(FN_INSERT, 0, 32'sh7fffffff, 0);
		send_word(FN_INSERT, 0, 32'sh80000000, 0);
		send_word(FN_INSERT, 0, -1, 2);
		send_word(FN_INSERT, 0, 0, 0);
		send_word(FN_INSERT, 0, 0, 0);
		send_word(FN_GET_MIN, 0, 0, 0);
		send_word(FN_CHANGE, 2, 32'sh7fffffff, 0);
		send_word(FN_GET_MIN, 0, 0, 0);
		send_word(FN_DELETE, 1, 0, 0);
		send_word(FN_DELETE, 1, 0, 0);
		send_word(FN_EXTRACT_MIN, 0, 0, 0);
		send_word(FN_EXTRACT_MIN, 0, 0, 0);
		send_word(FN_CLEAR, 0, 0, 0);
		send_word(FN_GET_MIN, 0, 0, 0);
		send_word(FN_CHANGE, 3, 5, 0);
		send_word(FN_INSERT, 0, 7, 0);
		send_word(FN_SIZE, 0, 0, 3);

		// random mix
		repeat (200) send_random();

		// fill to capacity, then overflow and work on a full heap
		send_word(FN_CLEAR, 0, 0, 0);
		repeat (1030) send_word(FN_INSERT, HANDLE_W'($urandom), pick_value(),
			($urandom_range(0, 15) == 0) ? pick_gap() : 0);
		repeat (20) send_random();

		// handles never issued, then a final mix
		send_word(FN_CHANGE, 12'hfff, 1, 0);
		send_word(FN_DELETE, 12'hffe, 0, 0);
		repeat (30) send_random();
		start = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("sent %0d command words (%0d inserts), checked %0d result words",
			words_sent, inserts_sent, words_checked);
		$display("covered empty and full heap, overflow, stale and unissued handles");
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
